### sv/proximity_light_sensor_logic_unit_macros.svh
// ----------------------------------------------------------------------------
// proximity light sensor logic unit - assertion macros
// shared concurrent assertion forms, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_LIGHT_SENSOR_LOGIC_UNIT_MACROS_SVH
`define PROXIMITY_LIGHT_SENSOR_LOGIC_UNIT_MACROS_SVH

// assertion on an explicit clock and reset
`define PLSLU_ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assertion on the block clock and reset
`define PLSLU_ASSERT(lbl, prop, msg) \
   `PLSLU_ASSERT_AT(lbl, clock, reset, prop, msg)

`endif

### sv/plslu_pkg.sv
// ----------------------------------------------------------------------------
// plslu_pkg
// types, operation codes and tables of the proximity light sensor logic unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plslu_pkg;

   // operation codes
   localparam logic [2:0] OP_IR_SAMPLE    = 3'd0;
   localparam logic [2:0] OP_PROX_SAMPLE  = 3'd1;
   localparam logic [2:0] OP_LIGHT_SAMPLE = 3'd2;
   localparam logic [2:0] OP_PROX_ENABLE  = 3'd3;
   localparam logic [2:0] OP_LIGHT_OPEN   = 3'd4;

   // distance decisions
   localparam logic [1:0] DEC_CLOSE = 2'd0;
   localparam logic [1:0] DEC_FAR   = 2'd1;
   localparam logic [1:0] DEC_NONE  = 2'd2;

   // configuration register indexes
   localparam logic CSR_HIGH_THRESHOLDS = 1'b0;
   localparam logic CSR_LOW_THRESHOLDS  = 1'b1;

   localparam logic [47:0] HIGH_THRESHOLDS_RESET = 48'd2062675764000;
   localparam logic [47:0] LOW_THRESHOLDS_RESET  = 48'd825389433552;
   localparam logic [11:0] CLOSE_RESET = 12'd800;
   localparam logic [11:0] FAR_RESET   = 12'd720;

   localparam int ADC_SPAN  = 4096;
   localparam int UP_MARGIN = 200;
   localparam int GATE_DIV  = 5;
   localparam logic [12:0] UP_LIMIT  = 13'(ADC_SPAN - UP_MARGIN);
   localparam logic [11:0] DOWN_BASE = 12'(ADC_SPAN - ADC_SPAN / GATE_DIV);
   localparam logic [11:0] SAMPLE_MAX = 12'hFFF;

   localparam logic [10:0] ADC_EDGE [16] = '{
      11'd5, 11'd20, 11'd32, 11'd64, 11'd256, 11'd640, 11'd1024, 11'd1024,
      11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024
   };
   localparam logic [13:0] LUX_OF_LEVEL [16] = '{
      14'd10, 14'd225, 14'd320, 14'd640, 14'd1280, 14'd2600, 14'd10240, 14'd10240,
      14'd10240, 14'd10240, 14'd10240, 14'd10240, 14'd10240, 14'd10240, 14'd10240,
      14'd10240
   };

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] sample;
      logic        cycle_start;
   } req_payload_type;

   typedef struct packed {
      logic        remeasure;
      logic [1:0]  range_select;
      logic        distance_valid;
      logic        distance_far;
      logic        light_valid;
      logic        light_invalid;
      logic [13:0] lux;
      logic [2:0]  light_level;
   } rsp_payload_type;

   // classified item between front and back
   typedef struct packed {
      logic [2:0]  op;
      logic [11:0] sample;
      logic        cycle_start;
      logic [3:0]  level;
   } cmd_type;

   // per-range 12-bit threshold, ranges past three use range three
   function automatic logic [11:0] field_of(input logic [47:0] packed_thr,
                                            input logic [2:0] r);
      logic [11:0] f;
      case (r)
         3'd0:    f = packed_thr[11:0];
         3'd1:    f = packed_thr[23:12];
         3'd2:    f = packed_thr[35:24];
         default: f = packed_thr[47:36];
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

### sv/proximity_light_sensor_logic_unit.sv
// ----------------------------------------------------------------------------
// proximity_light_sensor_logic_unit
// auto-range, proximity and ambient-light decision logic
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transfer (infrared, proximity or light
//   sample, proximity enable, light open); rsp_* returns exactly one result
//   per request, in order. csr_* writes the packed close/far thresholds
//   (index 0 close, index 1 far); the user must do so only while the block is idle,
//   which the block itself does not enforce.
//   A request is held in a queue entry, then its result in the result
//   register, which drives rsp_valid and rsp_payload.
//   Throughput: one request per cycle while rsp_stall is low; the decision
//   stage does all of an item's work as it is popped and the two-entry queue
//   keeps the input open while a result waits.
//   Reset (synchronous, active high) restores the threshold registers, range
//   zero, no prior decision and the first-light-read marker; queue and
//   result register come up empty.
//   When the receiver holds rsp_stall the result holds, the queue fills and
//   req_stall rises once both queue entries are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module proximity_light_sensor_logic_unit #(
   parameter int NUM_RANGES   = 4,
   parameter int LIGHT_LEVELS = 7,
   parameter int MAX_RETRIES  = 3
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  plslu_pkg::req_payload_type req_payload,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output plslu_pkg::rsp_payload_type rsp_payload,
   input  wire                        rsp_stall,
   input  wire                        csr_we,
   input  wire                        csr_index,
   input  wire  [47:0]                csr_wdata
);
   import plslu_pkg::*;

   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   plslu_front #(
      .LIGHT_LEVELS(LIGHT_LEVELS)
   ) u_front (
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   plslu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop_valid(back_valid),
      .pop_ready(back_ready),
      .pop_cmd  (back_cmd)
   );

   plslu_back #(
      .NUM_RANGES (NUM_RANGES),
      .MAX_RETRIES(MAX_RETRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (back_valid),
      .cmd        (back_cmd),
      .cmd_ready  (back_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

### sv/plslu_front.sv
// ----------------------------------------------------------------------------
// plslu_front
// accepts request transfers, clamps the sample and finds the light level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plslu_front #(
   parameter int LIGHT_LEVELS = 7
) (
   input  wire                        req_valid,
   input  plslu_pkg::req_payload_type req_payload,
   output logic                       req_stall,
   input  wire                        q_full,
   output logic                       q_push,
   output plslu_pkg::cmd_type         q_cmd
);
   import plslu_pkg::*;

   logic [11:0] sample_clamped;
   logic [3:0]  level;

   assign sample_clamped = (req_payload.sample[15:12] != 4'd0) ? SAMPLE_MAX
                                                                : req_payload.sample[11:0];

   // first table edge above the count, highest level when none is
   always_comb begin
      level = 4'(LIGHT_LEVELS - 1);
      for (int i = LIGHT_LEVELS - 1; i >= 0; i--) begin
         if ({1'b0, sample_clamped} < {2'b00, ADC_EDGE[i]}) begin
            level = 4'(i);
         end
      end
   end

   assign req_stall         = q_full;
   assign q_push            = req_valid && !q_full;
   assign q_cmd.op          = req_payload.op;
   assign q_cmd.sample      = sample_clamped;
   assign q_cmd.cycle_start = req_payload.cycle_start;
   assign q_cmd.level       = level;

endmodule

`default_nettype wire

### sv/plslu_queue.sv
// ----------------------------------------------------------------------------
// plslu_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "proximity_light_sensor_logic_unit_macros.svh"

module plslu_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  plslu_pkg::cmd_type push_cmd,
   output logic               full,
   output logic               pop_valid,
   input  wire                pop_ready,
   output plslu_pkg::cmd_type pop_cmd
);
   import plslu_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PLSLU_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "queue count above depth")
   `PLSLU_ASSERT(a_push_grows, (push && !pop) |=> count_ff == CW'($past(count_ff) + 1'b1), "queue did not grow on push")

endmodule

`default_nettype wire

### sv/plslu_back.sv
// ----------------------------------------------------------------------------
// plslu_back
// auto-range, distance and light decisions with the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "proximity_light_sensor_logic_unit_macros.svh"

module plslu_back #(
   parameter int NUM_RANGES  = 4,
   parameter int MAX_RETRIES = 3
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire                        csr_index,
   input  wire  [47:0]                csr_wdata,
   input  wire                        cmd_valid,
   input  plslu_pkg::cmd_type         cmd,
   output logic                       cmd_ready,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output plslu_pkg::rsp_payload_type rsp_payload
);
   import plslu_pkg::*;

   localparam int RW  = $clog2(NUM_RANGES);
   localparam int RCW = $clog2(MAX_RETRIES + 1);

   logic [47:0]     high_ff, low_ff;
   logic [RW-1:0]   range_ff, range_in;
   logic [RCW-1:0]  retry_ff, retry_in;
   logic [11:0]     ir_ff, ir_in;
   logic [11:0]     close_ff, close_in;
   logic [11:0]     far_ff, far_in;
   logic [1:0]      dec_ff, dec_in;
   logic            first_ff, first_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            pop;
   logic [2:0]      range_ext, range_next_ext;
   logic [11:0]     hi_cur, lo_cur, hi_prev;
   logic [RCW-1:0]  retry_eff;
   logic            can_retry, up_hit, down_hit;
   logic [12:0]     close_sum, far_sum;
   logic [1:0]      flag;

   assign cmd_ready = !rsp_valid_ff || !rsp_stall;
   assign pop       = cmd_valid && cmd_ready;

   assign range_ext = 3'(range_ff);
   assign hi_cur    = field_of(high_ff, range_ext);
   assign lo_cur    = field_of(low_ff, range_ext);
   assign hi_prev   = field_of(high_ff, 3'(range_ext - 3'd1));
   assign retry_eff = cmd.cycle_start ? '0 : retry_ff;
   assign can_retry = (retry_eff < RCW'(MAX_RETRIES));

   // s > 4096 - hi - 200, kept unsigned as s + hi > limit
   assign up_hit   = ({1'b0, cmd.sample} + {1'b0, hi_cur}) > UP_LIMIT;
   // a negative down limit is never undercut, range zero has none
   assign down_hit = (range_ff != '0) && (hi_prev <= DOWN_BASE)
                     && (cmd.sample < ((DOWN_BASE - hi_prev) >> 2));

   assign close_sum = {1'b0, ir_ff} + {1'b0, close_ff};
   assign far_sum   = {1'b0, ir_ff} + {1'b0, far_ff};

   always_comb begin
      if ({1'b0, cmd.sample} > close_sum) begin
         flag = DEC_CLOSE;
      end else if ({1'b0, cmd.sample} < far_sum) begin
         flag = DEC_FAR;
      end else begin
         flag = DEC_NONE;
      end
   end

   always_comb begin
      range_in = range_ff;
      retry_in = retry_ff;
      ir_in    = ir_ff;
      close_in = close_ff;
      far_in   = far_ff;
      dec_in   = dec_ff;
      first_in = first_ff;
      rsp_in   = '0;
      if (pop) begin
         case (cmd.op)
            OP_IR_SAMPLE: begin
               retry_in = retry_eff;
               close_in = hi_cur;
               far_in   = lo_cur;
               ir_in    = cmd.sample;
               if (up_hit) begin
                  if (can_retry && (range_ff != RW'(NUM_RANGES - 1))) begin
                     range_in         = RW'(range_ff + 1'b1);
                     retry_in         = RCW'(retry_eff + 1'b1);
                     rsp_in.remeasure = 1'b1;
                  end
               end else if (down_hit) begin
                  if (can_retry) begin
                     range_in         = RW'(range_ff - 1'b1);
                     retry_in         = RCW'(retry_eff + 1'b1);
                     rsp_in.remeasure = 1'b1;
                  end
               end
            end
            OP_PROX_SAMPLE: begin
               // close only reported on a second close in a row
               if (flag == DEC_FAR) begin
                  rsp_in.distance_valid = 1'b1;
                  rsp_in.distance_far   = 1'b1;
               end else if (flag == DEC_CLOSE && dec_ff == DEC_CLOSE) begin
                  rsp_in.distance_valid = 1'b1;
               end
               dec_in = flag;
            end
            OP_LIGHT_SAMPLE: begin
               rsp_in.light_valid = 1'b1;
               rsp_in.light_level = cmd.level[2:0];
               if (first_ff) begin
                  first_in             = 1'b0;
                  rsp_in.light_invalid = 1'b1;
               end else begin
                  rsp_in.lux = LUX_OF_LEVEL[cmd.level];
               end
            end
            OP_PROX_ENABLE: begin
               range_in = '0;
            end
            OP_LIGHT_OPEN: begin
               first_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      range_next_ext      = 3'(range_in);
      rsp_in.range_select = range_next_ext[1:0];
      rsp_valid_in        = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff      <= HIGH_THRESHOLDS_RESET;
         low_ff       <= LOW_THRESHOLDS_RESET;
         range_ff     <= '0;
         retry_ff     <= '0;
         ir_ff        <= '0;
         close_ff     <= CLOSE_RESET;
         far_ff       <= FAR_RESET;
         dec_ff       <= DEC_NONE;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HIGH_THRESHOLDS: high_ff <= csr_wdata;
               CSR_LOW_THRESHOLDS:  low_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         range_ff     <= range_in;
         retry_ff     <= retry_in;
         ir_ff        <= ir_in;
         close_ff     <= close_in;
         far_ff       <= far_in;
         dec_ff       <= dec_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PLSLU_ASSERT(a_retry_bound, retry_ff <= RCW'(MAX_RETRIES), "retry count above limit")
   `PLSLU_ASSERT(a_one_report, rsp_valid_ff |-> !(rsp_ff.distance_valid && rsp_ff.light_valid) && !(rsp_ff.remeasure && (rsp_ff.distance_valid || rsp_ff.light_valid)), "more than one kind of report")
   `PLSLU_ASSERT(a_marker_lux, (rsp_valid_ff && rsp_ff.light_invalid) |-> (rsp_ff.light_valid && rsp_ff.lux == 14'd0), "light marker carries lux")

endmodule

`default_nettype wire
